// ===== rtl/amalp_pkg.sv =====
package amalp_pkg;

    localparam int NUM_AXES       = 3;
    localparam int SAMPLE_W       = 16;
    localparam int OUT_W          = 24;
    localparam int ALPHA_W        = 17;
    localparam int ALPHA_FRAC     = 16;
    localparam int LEVEL_W        = 34;
    localparam int OUT_SHIFT      = 8;
    localparam int SCALED_W       = 32;
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW        = $clog2(FIFO_DEPTH + 1);
    localparam int DEF_WINDOW_LEN = 8;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SCALED_W-1:0] scaled_t;
    typedef logic signed [LEVEL_W-1:0]  level_t;

    // Window average times alpha, one per axis: the feed-forward term of the filter.
    typedef struct packed {
        scaled_t [NUM_AXES-1:0] target;
    } queue_entry_t;

endpackage

// ===== rtl/amalp_front.sv =====
module amalp_front
    import amalp_pkg::*;
#(
    parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  sample_t [NUM_AXES-1:0]        in_sample,
    input  logic [ALPHA_W-1:0]            alpha,
    output logic                          out_valid,
    output queue_entry_t                  out_entry,
    output logic [1:0]                    inflight
);

    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUOT_W      = SAMPLE_W + 1;
    localparam int MULT_W      = SAMPLE_W + ALPHA_W + 1;
    // Rounded-up reciprocal; exact for every window sum magnitude.
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT)
                                           + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    sample_t                   win_reg   [NUM_AXES][WINDOW_LEN];
    logic signed [SUM_W-1:0]   sum_reg   [NUM_AXES];
    logic [PROD_W-1:0]         quot_reg  [NUM_AXES];
    logic                      neg_reg   [NUM_AXES];
    scaled_t                   target_reg[NUM_AXES];
    logic                      v1_reg, v2_reg, v3_reg;

    logic [SUM_W-1:0]          mag       [NUM_AXES];
    logic signed [MULT_W-1:0]  avg_prod  [NUM_AXES];
    logic [QUOT_W-1:0]         quot      [NUM_AXES];
    logic [QUOT_W-1:0]         avg_bits  [NUM_AXES];

    // Window shift line and running sum: add the new sample, drop the oldest.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                sum_reg[a] <= '0;
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    win_reg[a][i] <= '0;
                end
            end
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (in_valid) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    for (int i = WINDOW_LEN - 1; i > 0; i--) begin
                        win_reg[a][i] <= win_reg[a][i-1];
                    end
                    win_reg[a][0] <= in_sample[a];
                    sum_reg[a] <= sum_reg[a] + SUM_W'(in_sample[a])
                                  - SUM_W'(win_reg[a][WINDOW_LEN-1]);
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            mag[a]      = sum_reg[a][SUM_W-1] ? (-sum_reg[a]) : sum_reg[a];
            quot[a]     = quot_reg[a][RECIP_SHIFT +: QUOT_W];
            avg_bits[a] = neg_reg[a] ? (-quot[a]) : quot[a];
            avg_prod[a] = $signed(avg_bits[a][SAMPLE_W-1:0]) * $signed({1'b0, alpha});
        end
    end

    // Divide by the window length through the reciprocal, then scale by alpha.
    always_ff @(posedge aclk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            quot_reg[a]   <= PROD_W'(mag[a]) * PROD_W'(RECIP);
            neg_reg[a]    <= sum_reg[a][SUM_W-1];
            target_reg[a] <= avg_prod[a][SCALED_W-1:0];
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            out_entry.target[a] = target_reg[a];
        end
    end

    assign out_valid = v3_reg;
    assign inflight  = {1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, v3_reg};

endmodule

// ===== rtl/amalp_queue.sv =====
module amalp_queue
    import amalp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  queue_entry_t         push_entry,
    input  logic                 pop,
    output queue_entry_t         head_entry,
    output logic                 not_empty,
    output logic [FIFO_CW-1:0]   count
);

    queue_entry_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]        count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
        end
    end

    assign head_entry = mem_reg[rd_ptr_reg];
    assign not_empty  = (count_reg != '0);
    assign count      = count_reg;

endmodule

// ===== rtl/amalp_back.sv =====
module amalp_back
    import amalp_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  queue_entry_t                  in_entry,
    input  logic [ALPHA_W-1:0]            alpha,
    output logic                          in_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [NUM_AXES*OUT_W-1:0]     m_tdata
);

    localparam int FB_W = LEVEL_W + ALPHA_W + 1;
    localparam logic signed [FB_W-1:0] ROUND_UP = FB_W'((1 << ALPHA_FRAC) - 1);

    level_t                      level_reg [NUM_AXES];
    logic                        valid_reg;
    logic [NUM_AXES*OUT_W-1:0]   data_reg;

    logic signed [FB_W-1:0]      fb_prod   [NUM_AXES];
    logic signed [FB_W-1:0]      fb_term   [NUM_AXES];
    logic signed [FB_W-1:0]      upd       [NUM_AXES];
    level_t                      level_next[NUM_AXES];
    logic [NUM_AXES*OUT_W-1:0]   data_next;

    assign in_pop = in_valid && (!valid_reg || m_tready);

    // level + ((avg<<16 - level) * alpha >>> 16) == level + avg*alpha - ceil(level*alpha / 2^16)
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            fb_prod[a]    = level_reg[a] * $signed({1'b0, alpha});
            fb_term[a]    = (fb_prod[a] + ROUND_UP) >>> ALPHA_FRAC;
            upd[a]        = FB_W'(level_reg[a]) + FB_W'(in_entry.target[a]) - fb_term[a];
            level_next[a] = upd[a][LEVEL_W-1:0];
            data_next[a*OUT_W +: OUT_W] = level_next[a][OUT_SHIFT +: OUT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                level_reg[a] <= '0;
            end
        end else if (in_pop) begin
            valid_reg <= 1'b1;
            for (int a = 0; a < NUM_AXES; a++) begin
                level_reg[a] <= level_next[a];
            end
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_pop) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== rtl/attitude_moving_average_lowpass_core.sv =====
// Attitude smoother: per-axis moving average followed by a single-pole low-pass.
// Input stream (s_*): one beat carries a signed roll, pitch and yaw sample in
// hundredths of a degree. Output stream (m_*): one beat per input beat with the
// filtered angles, hundredths of a degree with 8 fraction bits.
// Configuration: cfg_wr_en writes cfg_wr_data as the Q16 gain alpha (values
// above one are clamped to one); write it only while the block is idle.
// Output: an accepted beat passes the front pipeline and the queue into the output
// register. Throughput: one beat per cycle while m_tready stays high.
// The front (window sums, divide by the window length, scaling by alpha) is a
// 3-stage pipeline that never stalls; the recursive filter update, one multiply,
// a rounding add, an add and a subtract per axis, is combinational in the back end.
// An 8-entry queue sits between them; s_tready drops only when the queue plus
// the beats still in the front could fill it, so a stalled receiver holds its
// result in the output register while the queue soaks up the pipeline.
// Reset: windows, running sums and filter levels clear to zero, alpha returns
// to 6554 (about 0.1), m_tvalid goes low and s_tready comes up at once.
module attitude_moving_average_lowpass_core
    import amalp_pkg::*;
#(
    parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [NUM_AXES*SAMPLE_W-1:0]  s_tdata,   // roll_sample, pitch_sample, yaw_sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [NUM_AXES*OUT_W-1:0]     m_tdata,   // roll_smoothed, pitch_smoothed, yaw_smoothed
    input  logic                          cfg_wr_en,
    input  logic [ALPHA_W-1:0]            cfg_wr_data // smoothing_alpha
);

    logic [ALPHA_W-1:0]        alpha_reg;
    logic                      s_accept;
    sample_t [NUM_AXES-1:0]    in_sample;
    logic                      front_valid;
    queue_entry_t              front_entry;
    logic [1:0]                front_inflight;
    queue_entry_t              head_entry;
    logic                      queue_not_empty;
    logic                      queue_pop;
    logic [FIFO_CW-1:0]        queue_count;
    logic [FIFO_CW:0]          credits_used;

    // Hold the clamped gain; no read-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
        end else if (cfg_wr_en) begin
            alpha_reg <= (cfg_wr_data > ALPHA_ONE) ? ALPHA_ONE : cfg_wr_data;
        end
    end

    // Accept only while every beat in flight is sure of a queue slot.
    assign credits_used = {1'b0, queue_count} + (FIFO_CW + 1)'(front_inflight);
    assign s_tready     = (credits_used < (FIFO_CW + 1)'(FIFO_DEPTH));
    assign s_accept     = s_tvalid && s_tready;

    // Unpack the beat, roll in the low bits.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            in_sample[a] = s_tdata[a*SAMPLE_W +: SAMPLE_W];
        end
    end

    amalp_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_accept),
        .in_sample (in_sample),
        .alpha     (alpha_reg),
        .out_valid (front_valid),
        .out_entry (front_entry),
        .inflight  (front_inflight)
    );

    amalp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_valid),
        .push_entry (front_entry),
        .pop        (queue_pop),
        .head_entry (head_entry),
        .not_empty  (queue_not_empty),
        .count      (queue_count)
    );

    // Advance the filter one step per popped entry, into the output register.
    amalp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (queue_not_empty),
        .in_entry (head_entry),
        .alpha    (alpha_reg),
        .in_pop   (queue_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/amalp_checker.sv =====
module amalp_checker
    import amalp_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [NUM_AXES*OUT_W-1:0]     m_tdata
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed or dropped");

    // Drop m_tvalid right out of reset.
    a_reset_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid after reset");

    // Raise s_tready right out of reset: nothing is in flight.
    a_reset_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> s_tready)
        else $error("input not ready after reset");

    // A result appearing on an idle output comes from a beat taken through the front and the queue.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
        else $error("output beat without a matching input beat");

endmodule

bind attitude_moving_average_lowpass_core amalp_checker u_amalp_checker (.*);
